[rtl/core/greedy_change_breakdown_macros.svh]
// Assertion macros used by the checker of the greedy change breakdown block.
`ifndef GREEDY_CHANGE_BREAKDOWN_MACROS_SVH
`define GREEDY_CHANGE_BREAKDOWN_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define GCB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define GCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gcb_pkg.sv]
// Package with widths, register codes and types of the greedy change breakdown block.
`default_nettype none

package gcb_pkg;

  localparam int VAL_W             = 20;
  localparam int CNT_REG_W         = 3;
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 20;
  localparam int MAX_DENOM_DEFAULT = 6;

  localparam logic [CFG_IDX_W-1:0] REG_DENOM_COUNT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KIND_MASK   = 4'd7;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;
  localparam logic KIND_COIN    = 1'b0;

  typedef logic [VAL_W-1:0] val_t;

  typedef struct packed {
    logic kind;
    val_t unit_value;
    val_t how_many;
    logic status;
    logic last;
  } result_t;

  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    val_t quot;
    val_t rem;
  } div_rsp_t;

endpackage

`default_nettype wire

[rtl/core/gcb_channel_if.sv]
// Valid/ready channel interfaces for requests, results and configuration writes.
`default_nettype none

interface gcb_in_if;
  logic         valid;
  logic         ready;
  gcb_pkg::val_t price;
  gcb_pkg::val_t paid;

  modport source (output valid, output price, output paid, input ready);
  modport sink   (input valid, input price, input paid, output ready);
endinterface

interface gcb_out_if;
  logic          valid;
  logic          ready;
  logic          kind;
  gcb_pkg::val_t unit_value;
  gcb_pkg::val_t how_many;
  logic          status;
  logic          last;

  modport source (output valid, output kind, output unit_value, output how_many,
                  output status, output last, input ready);
  modport sink   (input valid, input kind, input unit_value, input how_many,
                  input status, input last, output ready);
endinterface

interface gcb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gcb_pkg::CFG_IDX_W-1:0]  index;
  logic [gcb_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/gcb_divider.sv]
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module gcb_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gcb_pkg::div_req_t req,
  output gcb_pkg::div_rsp_t      rsp
);

  localparam int STEP_W = $clog2(gcb_pkg::VAL_W);

  gcb_pkg::val_t     rem_r;
  gcb_pkg::val_t     quot_r;
  gcb_pkg::val_t     dsor_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [gcb_pkg::VAL_W:0] shifted;
  gcb_pkg::val_t           diff;
  logic                    fits;

  // The partial remainder stays below the divisor, so one more bit fits in VAL_W+1.
  assign shifted = {rem_r, quot_r[gcb_pkg::VAL_W-1]};
  assign diff    = shifted[gcb_pkg::VAL_W-1:0] - dsor_r;
  assign fits    = (shifted >= {1'b0, dsor_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (step_r == '0)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= '0;
      quot_r <= req.dividend;
      dsor_r <= req.divisor;
      step_r <= STEP_W'(gcb_pkg::VAL_W - 1);
    end else if (busy_r) begin
      rem_r  <= fits ? diff : shifted[gcb_pkg::VAL_W-1:0];
      quot_r <= {quot_r[gcb_pkg::VAL_W-2:0], fits};
      step_r <= step_r - 1'b1;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

[rtl/core/greedy_change_breakdown.sv]
// Top level of the greedy change breakdown block: configuration, sequencer and result register.
//
// Usage:
//   cfg_ch writes the denomination registers (index 0..5), the count in use (6) and the
//   bill/coin mask (7); it is always ready and a write to any other index is ignored.
//   in_ch takes one request of price and paid. in_ch.ready is high only while the
//   sequencer is idle, so one request is worked on at a time.
//   out_ch returns one to six results per request; the final one has last set.
//   A short payment gives a single result with status set.
// Sequence:
//   Denominations are visited from the highest index in use down to zero. Each nonzero
//   one starts the shared divider in S_PICK, waits in S_DIV for the restoring division
//   and retires there; a zero one is skipped in S_PICK.
// Stalls:
//   Results leave through an output register. While the receiver stalls, the sequencer
//   waits only when it must move a result into a full output register; the next
//   request is accepted while the final result still waits there.
// Reset: rst_n, synchronous, clears the registers, the sequencer and the output valid.
`default_nettype none

module greedy_change_breakdown #(
  parameter int MAX_DENOMINATIONS = gcb_pkg::MAX_DENOM_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst_n,
  gcb_cfg_if.sink   cfg_ch,
  gcb_in_if.sink    in_ch,
  gcb_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_DENOMINATIONS + 1);
  localparam int IDX_W = (MAX_DENOMINATIONS > 1) ? $clog2(MAX_DENOMINATIONS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PICK  = 4'b0010,
    S_DIV   = 4'b0100,
    S_FINAL = 4'b1000
  } state_t;

  gcb_pkg::val_t                 denom_r [MAX_DENOMINATIONS];
  logic [gcb_pkg::CNT_REG_W-1:0] count_r;
  logic [MAX_DENOMINATIONS-1:0]  kind_mask_r;

  state_t            state_r, state_nxt;
  gcb_pkg::val_t     rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              have_r, have_nxt;
  gcb_pkg::result_t  pend_r, pend_nxt;
  gcb_pkg::result_t  out_r, out_nxt;
  logic              out_vld_r, out_vld_nxt;

  gcb_pkg::div_req_t div_req;
  gcb_pkg::div_rsp_t div_rsp;

  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  idx_full;
  logic [IDX_W-1:0]  idx;
  logic              out_free;
  gcb_pkg::result_t  found;

  gcb_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Configuration registers. Denomination slots beyond the parameter are never read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DENOMINATIONS; i++) begin
        denom_r[i] <= '0;
      end
      count_r     <= '0;
      kind_mask_r <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index < gcb_pkg::CFG_IDX_W'(MAX_DENOMINATIONS)) begin
        denom_r[cfg_ch.index[IDX_W-1:0]] <= cfg_ch.data[gcb_pkg::VAL_W-1:0];
      end else if (cfg_ch.index == gcb_pkg::REG_DENOM_COUNT) begin
        count_r <= cfg_ch.data[gcb_pkg::CNT_REG_W-1:0];
      end else if (cfg_ch.index == gcb_pkg::REG_KIND_MASK) begin
        kind_mask_r <= cfg_ch.data[MAX_DENOMINATIONS-1:0];
      end
    end
  end

  assign cfg_ch.ready = 1'b1;

  assign used = (count_r > gcb_pkg::CNT_REG_W'(MAX_DENOMINATIONS)) ?
                CNT_W'(MAX_DENOMINATIONS) : CNT_W'(count_r);
  assign idx_full = cnt_r - 1'b1;
  assign idx      = idx_full[IDX_W-1:0];
  assign out_free = !out_vld_r || out_ch.ready;

  always_comb begin
    found.kind       = kind_mask_r[idx];
    found.unit_value = denom_r[idx];
    found.how_many   = div_rsp.quot;
    found.status     = gcb_pkg::STATUS_OK;
    found.last       = 1'b0;
  end

  // A found result waits in pend_r until the next one shows whether it is the last.
  always_comb begin
    state_nxt        = state_r;
    rem_nxt          = rem_r;
    cnt_nxt          = cnt_r;
    have_nxt         = have_r;
    pend_nxt         = pend_r;
    out_nxt          = out_r;
    out_vld_nxt      = out_vld_r && !out_ch.ready;
    div_req.start    = 1'b0;
    div_req.dividend = rem_r;
    div_req.divisor  = denom_r[idx];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.price > in_ch.paid) begin
            pend_nxt        = '0;
            pend_nxt.status = gcb_pkg::STATUS_SHORT;
            have_nxt        = 1'b1;
            state_nxt       = S_FINAL;
          end else begin
            rem_nxt   = in_ch.paid - in_ch.price;
            cnt_nxt   = used;
            have_nxt  = 1'b0;
            state_nxt = S_PICK;
          end
        end
      end
      S_PICK: begin
        if (cnt_r == '0) begin
          state_nxt = S_FINAL;
        end else if (denom_r[idx] == '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot == '0) begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_PICK;
          end else if (!have_r || out_free) begin
            if (have_r) begin
              out_nxt     = pend_r;
              out_vld_nxt = 1'b1;
            end
            pend_nxt  = found;
            have_nxt  = 1'b1;
            rem_nxt   = div_rsp.rem;
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_PICK;
          end
        end
      end
      S_FINAL: begin
        if (out_free) begin
          if (have_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt        = '0;
            out_nxt.kind   = gcb_pkg::KIND_COIN;
            out_nxt.status = gcb_pkg::STATUS_OK;
          end
          out_nxt.last = 1'b1;
          out_vld_nxt  = 1'b1;
          have_nxt     = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      have_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      have_r    <= have_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_vld_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.unit_value = out_r.unit_value;
  assign out_ch.how_many   = out_r.how_many;
  assign out_ch.status     = out_r.status;
  assign out_ch.last       = out_r.last;

endmodule

`default_nettype wire

[rtl/core/gcb_checker.sv]
// Port-level checker of the greedy change breakdown block and its bind to the top level.
`default_nettype none

`include "greedy_change_breakdown_macros.svh"

module gcb_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic          out_kind,
  input wire gcb_pkg::val_t out_unit_value,
  input wire gcb_pkg::val_t out_how_many,
  input wire logic          out_status,
  input wire logic          out_last
);

  // A stalled result keeps its contents.
  `GCB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_how_many) && $stable(out_unit_value) && $stable(out_last), "stalled result changed")

  // Only one request is in work at a time.
  `GCB_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready, "request taken while busy")

  // A short payment is a single empty result that closes the request.
  `GCB_ASSERT_NOW(a_short_empty, out_valid && out_status, out_last && !out_kind && out_how_many == '0 && out_unit_value == '0, "short payment result not empty")

  // A result that is not the last always hands back pieces.
  `GCB_ASSERT_NOW(a_mid_nonzero, out_valid && !out_last, out_how_many != '0 && out_unit_value != '0 && !out_status, "empty result before the last")

endmodule

bind greedy_change_breakdown gcb_checker u_gcb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_unit_value (out_ch.unit_value),
  .out_how_many   (out_ch.how_many),
  .out_status     (out_ch.status),
  .out_last       (out_ch.last)
);

`default_nettype wire

[tb/change_breakdown_monitor.sv]
// Monitor that predicts the change breakdown of every request and checks the results.
module change_breakdown_monitor import gcb_pkg::*; #(
  parameter int MAX_DENOMINATIONS = gcb_pkg::MAX_DENOM_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  gcb_cfg_if   cfg_ch,
  gcb_in_if    in_ch,
  gcb_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  val_t                 denom_value [6];
  logic [CNT_REG_W-1:0] denom_count;
  logic [5:0]           bill_mask;
  result_t              expected_change [$];
  result_t              arrived;
  result_t              wanted;

  task automatic report_error(string what);
    $display("%0d ns: result error: %s", $time, what);
    mismatches++;
  endtask

  // Adds one result at the tail of the expected queue.
  function automatic void queue_result(result_t item);
    expected_change.insert(expected_change.size(), item);
  endfunction

  // Appends the results one request should produce, in the order they leave the block.
  function automatic void predict_change(val_t price, val_t paid);
    int unsigned remaining;
    int unsigned pieces;
    int unsigned in_use;
    int          handed;
    result_t     item;
    item = '0;
    if (price > paid) begin
      item.status = STATUS_SHORT;
      item.last   = 1'b1;
      queue_result(item);
      return;
    end
    remaining = paid - price;
    in_use    = (denom_count > MAX_DENOMINATIONS) ? MAX_DENOMINATIONS : denom_count;
    if (in_use > 6) begin
      in_use = 6;
    end
    handed = 0;
    for (int i = int'(in_use) - 1; i >= 0; i--) begin
      if (denom_value[i] == '0) begin
        continue;
      end
      pieces = remaining / denom_value[i];
      if (pieces == 0) begin
        continue;
      end
      remaining -= pieces * denom_value[i];
      item.kind       = bill_mask[i];
      item.unit_value = denom_value[i];
      item.how_many   = val_t'(pieces);
      item.status     = STATUS_OK;
      item.last       = 1'b0;
      queue_result(item);
      handed++;
    end
    if (handed == 0) begin
      // Nothing fits: one empty result closes the request.
      item        = '0;
      item.kind   = KIND_COIN;
      item.status = STATUS_OK;
      item.last   = 1'b1;
      queue_result(item);
    end else begin
      item      = expected_change.pop_back();
      item.last = 1'b1;
      queue_result(item);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        denom_value[i] = '0;
      end
      denom_count = '0;
      bill_mask   = '0;
      expected_change.delete();
    end else begin
      // Results are retired before new requests are predicted in the same cycle.
      if (out_ch.valid && out_ch.ready) begin
        arrived.kind       = out_ch.kind;
        arrived.unit_value = out_ch.unit_value;
        arrived.how_many   = out_ch.how_many;
        arrived.status     = out_ch.status;
        arrived.last       = out_ch.last;
        if (expected_change.size() == 0) begin
          report_error($sformatf("unexpected result %p", arrived));
        end else begin
          wanted = expected_change.pop_front();
          if (arrived.kind !== wanted.kind) begin
            report_error($sformatf("kind %b, expected %b", arrived.kind, wanted.kind));
          end
          if (arrived.unit_value !== wanted.unit_value) begin
            report_error($sformatf("unit_value %0d, expected %0d",
                                   arrived.unit_value, wanted.unit_value));
          end
          if (arrived.how_many !== wanted.how_many) begin
            report_error($sformatf("how_many %0d, expected %0d",
                                   arrived.how_many, wanted.how_many));
          end
          if (arrived.status !== wanted.status) begin
            report_error($sformatf("status %b, expected %b", arrived.status, wanted.status));
          end
          if (arrived.last !== wanted.last) begin
            report_error($sformatf("last %b, expected %b", arrived.last, wanted.last));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_change(in_ch.price, in_ch.paid);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        // Denomination registers occupy the indexes below the count register.
        if (cfg_ch.index < REG_DENOM_COUNT) begin
          denom_value[cfg_ch.index] = cfg_ch.data[VAL_W-1:0];
        end else if (cfg_ch.index == REG_DENOM_COUNT) begin
          denom_count = cfg_ch.data[CNT_REG_W-1:0];
        end else if (cfg_ch.index == REG_KIND_MASK) begin
          bill_mask = cfg_ch.data[5:0];
        end
      end
    end
    outstanding <= expected_change.size();
  end

endmodule

[tb/tb_greedy_change_breakdown.sv]
// Top of the greedy change breakdown testbench: clock, reset, stimulus and verdict.
module tb_greedy_change_breakdown;
  timeunit 1ns;
  timeprecision 1ps;

  import gcb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_DENOM_0      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 200;
  localparam int STALL_AT      = 330;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 77;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   requests_sent = 0;
  int   cycle_count = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   calm = 1'b0;
  val_t coins [6];

  gcb_cfg_if cfg_ch ();
  gcb_in_if  in_ch ();
  gcb_out_if out_ch ();

  greedy_change_breakdown dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  change_breakdown_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("greedy_change_breakdown: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls, none while calm, and one long hold-off once the
  // request count passes STALL_AT so that the block backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && requests_sent >= STALL_AT) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  // Leaves valid high on return; the caller lowers it after the last write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic apply_config(val_t values [6], logic [CFG_DATA_W-1:0] count_word,
                              logic [CFG_DATA_W-1:0] mask_word, bit stray);
    if (stray) begin
      write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(7)),
                CFG_DATA_W'($urandom));
    end
    for (int i = 0; i < 6; i++) begin
      write_reg(REG_DENOM_0 + CFG_IDX_W'(i), values[i]);
    end
    write_reg(REG_DENOM_COUNT, count_word);
    write_reg(REG_KIND_MASK, mask_word);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_request(val_t price, val_t paid);
    while (!calm && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.price <= price;
    in_ch.paid  <= paid;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic val_t pick_amount();
    case ($urandom_range(4))
      0: return val_t'($urandom);
      1: return val_t'($urandom_range(0, 1000000));
      2: return ($urandom_range(1) == 1) ? '1 : val_t'(1000000);
      default: return val_t'($urandom_range(0, 1000));
    endcase
  endfunction

  task automatic random_request();
    val_t        price;
    logic [20:0] total;
    int unsigned change;
    price = pick_amount();
    if ($urandom_range(99) < 15) begin
      if (price == '0) begin
        price = val_t'($urandom_range(1, 1000));
      end
      send_request(price, price - val_t'($urandom_range(1, price)));
    end else begin
      case ($urandom_range(9))
        0: change = $urandom & 32'hFFFFF;
        1, 2, 3: change = $urandom_range(0, 1000000);
        default: change = $urandom_range(0, 1000);
      endcase
      total = {1'b0, price} + 21'(change);
      send_request(price, total[20] ? '1 : total[VAL_W-1:0]);
    end
  endtask

  task automatic random_config();
    val_t        values [6];
    int unsigned acc;
    int unsigned step_max;
    int          style;
    style    = $urandom_range(3);
    step_max = (style == 0) ? 25 : 170000;
    acc      = 0;
    for (int i = 0; i < 6; i++) begin
      acc += $urandom_range(1, step_max);
      values[i] = val_t'(acc);
      if (style == 2 && $urandom_range(2) == 0) begin
        values[i] = '0;
      end
      if (style == 3) begin
        values[i] = val_t'($urandom);
      end
    end
    apply_config(values,
                 ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(7)) : CFG_DATA_W'(6),
                 CFG_DATA_W'($urandom), $urandom_range(1) == 1);
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.price  <= '0;
    in_ch.paid   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: no denomination is in use.
    send_request('0, '0);
    send_request(val_t'(5), val_t'(3));
    send_request(val_t'(3), val_t'(5));
    send_request('1, '1);
    wait_idle();

    // Ordinary coin and bill set, all six in use.
    coins = '{val_t'(1), val_t'(5), val_t'(10), val_t'(25), val_t'(100), val_t'(500)};
    apply_config(coins, CFG_DATA_W'(6), CFG_DATA_W'(6'b110000), 1'b0);
    send_request('0, '0);
    send_request(val_t'(1), '0);
    send_request('0, '1);
    send_request('1, '1);
    send_request('1, '0);
    send_request(val_t'(1000000), val_t'(1000000));
    send_request(val_t'(37), val_t'(100));
    send_request('0, val_t'(666));
    wait_idle();

    // Zero and unsorted denominations, extreme values, a count that saturates,
    // an all-bill mask and a write to an index that does not exist.
    coins = '{'0, val_t'(7), '0, val_t'(3), '1, val_t'(1000000)};
    apply_config(coins, '1, CFG_DATA_W'(63), 1'b1);
    send_request('0, val_t'(1000000));
    send_request('0, '1);
    send_request('0, val_t'(10));
    send_request('0, val_t'(2));
    send_request(val_t'(5), val_t'(5));
    wait_idle();

    // Higher denominations beyond the count are ignored.
    apply_config(coins, CFG_DATA_W'(2), '0, 1'b0);
    send_request('0, val_t'(20));
    send_request(val_t'(3), val_t'(1000));
    wait_idle();
    apply_config(coins, '0, CFG_DATA_W'(63), 1'b0);
    send_request('0, val_t'(100));
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_config();
      calm = (phase == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_request();
      end
      wait_idle();
      calm = 1'b0;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("greedy_change_breakdown: match");
    end else begin
      $display("greedy_change_breakdown: mismatch");
    end
    $finish;
  end

endmodule
